### rtl/core/qoa_pkg.sv
// shared types, command codes and constants for the quaternion orientation accumulator
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none
package qoa_pkg;

	localparam int DEF_VALUE_WIDTH     = 32;
	localparam int DEF_TRIG_ITERATIONS = 24;

	// counter widths cover up to 64 trig iterations and a 32-bit value width
	localparam int CNT_W = 6;
	localparam int JOB_W = 6;

	// command codes
	localparam logic [1:0] CMD_RESET  = 2'd0;
	localparam logic [1:0] CMD_ROTATE = 2'd1;
	localparam logic [1:0] CMD_MULT   = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// multiplier job numbers: start of each segment
	localparam logic [JOB_W-1:0] JOB_SCALE  = 6'd0;
	localparam logic [JOB_W-1:0] JOB_SQUARE = 6'd3;
	localparam logic [JOB_W-1:0] JOB_QMUL   = 6'd7;
	localparam logic [JOB_W-1:0] JOB_MAT    = 6'd23;
	localparam logic [JOB_W-1:0] JOB_END    = 6'd32;

	// cordic in Q2.30 with headroom
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_K    = 34'sh0_26DD_3B6A;
	localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef struct packed {
		logic             load;
		logic             cordic_step;
		logic             cordic_fin;
		logic [CNT_W-1:0] cordic_iter;
		logic             mul_en;
		logic [JOB_W-1:0] mul_job;
		logic             sqrt_init;
		logic             sqrt_step;
		logic             div_init;
		logic             div_step;
		logic             div_fin;
		logic [1:0]       div_k;
		logic             commit;
		logic             out_load;
		logic [1:0]       out_row;
	} qoa_cmd_t;

	typedef struct packed {
		logic renorm_req;
		logic root_zero;
		logic out_free;
	} qoa_stat_t;

	// arctangent table, Q0.30, truncated past index 29
	function automatic logic [29:0] qoa_atan(input logic [CNT_W-1:0] i);
		logic [29:0] v;
		case (i)
			6'd0:  v = 30'h3243F6A8;
			6'd1:  v = 30'h1DAC6705;
			6'd2:  v = 30'h0FADBAFC;
			6'd3:  v = 30'h07F56EA6;
			6'd4:  v = 30'h03FEAB76;
			6'd5:  v = 30'h01FFD55B;
			6'd6:  v = 30'h00FFFAAA;
			6'd7:  v = 30'h007FFF55;
			6'd8:  v = 30'h003FFFEA;
			6'd9:  v = 30'h001FFFFD;
			6'd10: v = 30'h000FFFFF;
			6'd11: v = 30'h0007FFFF;
			6'd12: v = 30'h0003FFFF;
			6'd13: v = 30'h0001FFFF;
			6'd14: v = 30'h0000FFFF;
			6'd15: v = 30'h00007FFF;
			6'd16: v = 30'h00003FFF;
			6'd17: v = 30'h00001FFF;
			6'd18: v = 30'h00000FFF;
			6'd19: v = 30'h000007FF;
			6'd20: v = 30'h000003FF;
			6'd21: v = 30'h000001FF;
			6'd22: v = 30'h000000FF;
			6'd23: v = 30'h0000007F;
			6'd24: v = 30'h0000003F;
			6'd25: v = 30'h0000001F;
			6'd26: v = 30'h0000000F;
			6'd27: v = 30'h00000007;
			6'd28: v = 30'h00000003;
			6'd29: v = 30'h00000001;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

	// sign of term t of result component r in the hamilton product
	function automatic logic qmul_neg(input logic [1:0] r, input logic [1:0] t);
		return (r == 2'd0 && t != 2'd0) || (r == 2'd1 && t == 2'd3) ||
			(r == 2'd2 && t == 2'd1) || (r == 2'd3 && t == 2'd2);
	endfunction

endpackage
`default_nettype wire

### rtl/core/quaternion_orientation_accumulator.sv
// top level of the quaternion orientation accumulator
// depends on qoa_pkg, qoa_controller and qoa_datapath
//
// channel   direction  handshake            payload
// in        input      in_valid / in_ready  cmd, angle, axis_x..z, other_w..z
// out       output     out_valid / out_ready row_index, col_zero..two, quat_w..z, last_row
//
// one command at a time; the transfer, then the work, then the rows in order as the output frees
// reset or unused command: the nine matrix products before the three rows
// rotate work is set by the cordic loop, and rotate and multiply work by
// the single shared multiplier of at most 32x32 (32 jobs, one per cycle)
// rotate with renormalization adds a bit-serial square root and, unless the
// root is zero, a bit-serial division of each of the four components
// arst_n resets the orientation to identity; a stalled last row holds in the output
// register while the next command is taken, later rows wait for it
`default_nettype none
module quaternion_orientation_accumulator import qoa_pkg::*; #(
	parameter int VALUE_WIDTH     = DEF_VALUE_WIDTH,
	parameter int TRIG_ITERATIONS = DEF_TRIG_ITERATIONS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [31:0] angle,
	input  wire logic signed [31:0] axis_x,
	input  wire logic signed [31:0] axis_y,
	input  wire logic signed [31:0] axis_z,
	input  wire logic signed [31:0] other_w,
	input  wire logic signed [31:0] other_x,
	input  wire logic signed [31:0] other_y,
	input  wire logic signed [31:0] other_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              row_index,
	output logic signed [31:0]      col_zero,
	output logic signed [31:0]      col_one,
	output logic signed [31:0]      col_two,
	output logic signed [31:0]      quat_w,
	output logic signed [31:0]      quat_x,
	output logic signed [31:0]      quat_y,
	output logic signed [31:0]      quat_z,
	output logic                    last_row
);

	// values are held at most 32 bits wide, like the fields
	localparam int EFF_W = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;

	qoa_cmd_t  ctl;
	qoa_stat_t stat;

	// sequencer: cordic, scale, renorm, product, matrix, emit
	qoa_controller #(
		.W               (EFF_W),
		.TRIG_ITERATIONS (TRIG_ITERATIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.in_ready (in_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// arithmetic and the output register
	qoa_datapath #(
		.W (EFF_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_cmd    (cmd),
		.angle     (angle),
		.axis_x    (axis_x),
		.axis_y    (axis_y),
		.axis_z    (axis_z),
		.other_w   (other_w),
		.other_x   (other_x),
		.other_y   (other_y),
		.other_z   (other_z),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.row_index (row_index),
		.col_zero  (col_zero),
		.col_one   (col_one),
		.col_two   (col_two),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.last_row  (last_row)
	);

	// the final row is always row two
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_row |-> row_index == 2'd2)
		else $error("last_row on a row other than two");

	// a command transfer starts work, so the next cycle takes no command
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// only three rows exist
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_index != 2'd3)
		else $error("row index out of range");

endmodule
`default_nettype wire

### rtl/core/qoa_controller.sv
// sequencer for the quaternion orientation accumulator
// depends on qoa_pkg; drives the datapath through qoa_cmd_t
`default_nettype none
module qoa_controller import qoa_pkg::*; #(
	parameter int W               = DEF_VALUE_WIDTH,
	parameter int TRIG_ITERATIONS = DEF_TRIG_ITERATIONS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_cmd,
	output logic            in_ready,
	input  wire qoa_stat_t  stat,
	output qoa_cmd_t        ctl
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_CORDIC = 11'b00000000010,
		S_CFIN   = 11'b00000000100,
		S_SCALE  = 11'b00000001000,
		S_CHECK  = 11'b00000010000,
		S_SQRT   = 11'b00000100000,
		S_ROOT   = 11'b00001000000,
		S_DIV    = 11'b00010000000,
		S_QMUL   = 11'b00100000000,
		S_COMMIT = 11'b01000000000,
		S_EMIT   = 11'b10000000000
	} state_t;

	localparam logic [CNT_W-1:0] TRIG_LAST = CNT_W'(TRIG_ITERATIONS - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(W);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(W + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [JOB_W-1:0] job_q, job_d;
	logic [1:0]       k_q, k_d;
	logic [1:0]       row_q, row_d;
	logic             mat_q, mat_d;

	always_comb begin
		ctl         = '0;
		state_d     = state_q;
		cnt_d       = cnt_q;
		job_d       = job_q;
		k_d         = k_q;
		row_d       = row_q;
		mat_d       = mat_q;
		in_ready    = 1'b0;
		ctl.cordic_iter = cnt_q;
		ctl.mul_job = job_q;
		ctl.div_k   = k_q;
		ctl.out_row = row_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					cnt_d    = '0;
					case (in_cmd)
						CMD_ROTATE: state_d = S_CORDIC;
						CMD_MULT: begin
							job_d   = JOB_QMUL;
							mat_d   = 1'b0;
							state_d = S_QMUL;
						end
						default: begin
							job_d   = JOB_MAT;
							mat_d   = 1'b1;
							state_d = S_QMUL;
						end
					endcase
				end
			end
			S_CORDIC: begin
				ctl.cordic_step = 1'b1;
				if (cnt_q == TRIG_LAST) state_d = S_CFIN;
				else cnt_d = cnt_q + 1'b1;
			end
			S_CFIN: begin
				ctl.cordic_fin = 1'b1;
				job_d   = JOB_SCALE;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				if (job_q < JOB_QMUL) begin
					ctl.mul_en = 1'b1;
					job_d      = job_q + 1'b1;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cnt_d = '0;
				if (stat.renorm_req) begin
					state_d = S_SQRT;
				end else begin
					job_d   = JOB_QMUL;
					mat_d   = 1'b0;
					state_d = S_QMUL;
				end
			end
			S_SQRT: begin
				if (cnt_q == '0) ctl.sqrt_init = 1'b1;
				else ctl.sqrt_step = 1'b1;
				if (cnt_q == SQRT_LAST) state_d = S_ROOT;
				else cnt_d = cnt_q + 1'b1;
			end
			S_ROOT: begin
				cnt_d = '0;
				k_d   = '0;
				if (stat.root_zero) begin
					job_d   = JOB_QMUL;
					mat_d   = 1'b0;
					state_d = S_QMUL;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == '0) ctl.div_init = 1'b1;
				else if (cnt_q == DIV_LAST) ctl.div_fin = 1'b1;
				else ctl.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					if (k_q == 2'd3) begin
						job_d   = JOB_QMUL;
						mat_d   = 1'b0;
						state_d = S_QMUL;
					end else begin
						k_d = k_q + 1'b1;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_QMUL: begin
				// shared multiply sequencer for the product and the matrix jobs
				if ((!mat_q && job_q < JOB_MAT) || (mat_q && job_q < JOB_END)) begin
					ctl.mul_en = 1'b1;
					job_d      = job_q + 1'b1;
				end else if (!mat_q) begin
					state_d = S_COMMIT;
				end else begin
					row_d   = '0;
					state_d = S_EMIT;
				end
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				job_d   = JOB_MAT;
				mat_d   = 1'b1;
				state_d = S_QMUL;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					if (row_q == 2'd2) state_d = S_IDLE;
					else row_d = row_q + 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			job_q   <= '0;
			k_q     <= '0;
			row_q   <= '0;
			mat_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			job_q   <= job_d;
			k_q     <= k_d;
			row_q   <= row_d;
			mat_q   <= mat_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/qoa_datapath.sv
// datapath: shared multiplier, cordic, square root, divider, state and result register
// depends on qoa_pkg; sequenced by qoa_controller
`default_nettype none
module qoa_datapath import qoa_pkg::*; #(
	parameter int W = DEF_VALUE_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qoa_cmd_t           ctl,
	output qoa_stat_t               stat,
	input  wire logic [1:0]         in_cmd,
	input  wire logic signed [31:0] angle,
	input  wire logic signed [31:0] axis_x,
	input  wire logic signed [31:0] axis_y,
	input  wire logic signed [31:0] axis_z,
	input  wire logic signed [31:0] other_w,
	input  wire logic signed [31:0] other_x,
	input  wire logic signed [31:0] other_y,
	input  wire logic signed [31:0] other_z,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [1:0]              row_index,
	output logic signed [31:0]      col_zero,
	output logic signed [31:0]      col_one,
	output logic signed [31:0]      col_two,
	output logic signed [31:0]      quat_w,
	output logic signed [31:0]      quat_x,
	output logic signed [31:0]      quat_y,
	output logic signed [31:0]      quat_z,
	output logic                    last_row
);

	localparam int F  = W - 2;
	localparam int XW = (W + 6 > 36) ? W + 6 : 36;
	localparam int PW = 2 * W;
	localparam int RW = W + 2;
	localparam int AW = W + 4;

	localparam logic signed [XW-1:0] SAT_HI = signed'(XW'({1'b0, {(W-1){1'b1}}}));
	localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - 1;
	localparam logic signed [XW-1:0] ONE_X  = signed'(XW'(1) << F);
	localparam logic signed [W-1:0]  ONE_W  = signed'(W'(1) << F);
	localparam logic signed [PW-1:0] RND_HALF = signed'(PW'(1) << (F - 1));
	localparam logic [63:0] SCALE = 64'd1 << (2 * F - 2);
	localparam logic [63:0] HI_TH = (64'd6 * SCALE) / 64'd5;
	localparam logic [63:0] LO_TH = (64'd9 * SCALE + 64'd9) / 64'd10;

	function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
		logic signed [W-1:0] r;
		if (v > SAT_HI) r = SAT_HI[W-1:0];
		else if (v < SAT_LO) r = SAT_LO[W-1:0];
		else r = v[W-1:0];
		return r;
	endfunction

	// matrix products: yy zz xy wz xz wy xx yz wx
	function automatic logic [1:0] mat_a(input logic [3:0] i);
		logic [1:0] r;
		case (i)
			4'd0: r = 2'd2;
			4'd1: r = 2'd3;
			4'd2: r = 2'd1;
			4'd4: r = 2'd1;
			4'd6: r = 2'd1;
			4'd7: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mat_b(input logic [3:0] i);
		logic [1:0] r;
		case (i)
			4'd0: r = 2'd2;
			4'd1: r = 2'd3;
			4'd2: r = 2'd2;
			4'd3: r = 2'd3;
			4'd4: r = 2'd3;
			4'd5: r = 2'd2;
			4'd7: r = 2'd3;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	logic signed [W-1:0]  axis_q [3];
	logic signed [W-1:0]  q_q [4];
	logic signed [W-1:0]  s_q;
	logic signed [W-1:0]  orient_q [4];
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic                 neg_q;
	logic signed [PW-1:0] prod_q;
	logic [JOB_W-1:0]     tag_q;
	logic                 tag_vld_q;
	logic [PW-1:0]        m_q;
	logic signed [AW-1:0] acc_q [4];
	logic signed [RW-1:0] mp_q [9];
	logic [PW-1:0]        sv_q, sres_q, sbit_q;
	logic [W:0]           rem_q;
	logic [W-1:0]         numlo_q, quo_q;
	logic                 ovf_q, ng_q;
	logic [1:0]           row_q;
	logic signed [W-1:0]  col_q [3];
	logic signed [W-1:0]  qo_q [4];
	logic                 last_q;

	// operand select for the shared multiplier
	logic signed [W-1:0]  op_a, op_b;
	logic [JOB_W-1:0]     rel;
	always_comb begin
		op_a = '0;
		op_b = '0;
		rel  = '0;
		if (ctl.mul_job < JOB_SQUARE) begin
			rel  = ctl.mul_job - JOB_SCALE;
			op_a = axis_q[rel[1:0] == 2'd3 ? 2'd0 : rel[1:0]];
			op_b = s_q;
		end else if (ctl.mul_job < JOB_QMUL) begin
			rel  = ctl.mul_job - JOB_SQUARE;
			op_a = q_q[rel[1:0]];
			op_b = q_q[rel[1:0]];
		end else if (ctl.mul_job < JOB_MAT) begin
			rel  = ctl.mul_job - JOB_QMUL;
			op_a = orient_q[rel[1:0]];
			op_b = q_q[rel[3:2] ^ rel[1:0]];
		end else begin
			rel  = ctl.mul_job - JOB_MAT;
			op_a = orient_q[mat_a(rel[3:0])];
			op_b = orient_q[mat_b(rel[3:0])];
		end
	end

	// rounded product and job decode of the registered result
	logic signed [PW-1:0] prod_sum, prod_shr;
	logic signed [RW-1:0] rnd;
	logic [JOB_W-1:0]     trel;
	always_comb begin
		prod_sum = prod_q + RND_HALF;
		prod_shr = prod_sum >>> F;
		rnd      = prod_shr[RW-1:0];
		trel     = tag_q - JOB_QMUL;
	end

	// cordic step
	logic signed [CW-1:0] xs, ys, at, z0, xf, yf;
	always_comb begin
		xs = cx_q >>> ctl.cordic_iter;
		ys = cy_q >>> ctl.cordic_iter;
		at = signed'(CW'(qoa_atan(ctl.cordic_iter)));
		z0 = CW'(angle);
		xf = neg_q ? -cx_q : cx_q;
		yf = neg_q ? -cy_q : cy_q;
	end

	// square root step
	logic [PW-1:0] st_sum;
	assign st_sum = sres_q + sbit_q;

	// divider
	logic [W-1:0]        root, mag;
	logic [PW-1:0]       num;
	logic [W:0]          rem2;
	logic signed [W+1:0] qsv;
	logic signed [W-1:0] qdiv;
	always_comb begin
		root = sres_q[W-1:0];
		mag  = q_q[ctl.div_k][W-1] ? W'(-q_q[ctl.div_k]) : q_q[ctl.div_k];
		num  = (PW'(mag) << (F - 1)) + PW'(root >> 1);
		rem2 = {rem_q[W-1:0], numlo_q[W-1]};
		qsv  = ng_q ? -signed'({2'b00, quo_q}) : signed'({2'b00, quo_q});
		if (ovf_q) qdiv = ng_q ? SAT_LO[W-1:0] : SAT_HI[W-1:0];
		else qdiv = sat_w(XW'(qsv));
	end

	// matrix row from the stored products
	logic signed [XW-1:0] p [9];
	logic signed [XW-1:0] e0, e1, e2;
	always_comb begin
		for (int i = 0; i < 9; i++) p[i] = XW'(mp_q[i]);
		case (ctl.out_row)
			2'd0: begin
				e0 = ONE_X - ((p[0] + p[1]) <<< 1);
				e1 = (p[2] - p[3]) <<< 1;
				e2 = (p[4] + p[5]) <<< 1;
			end
			2'd1: begin
				e0 = (p[2] + p[3]) <<< 1;
				e1 = ONE_X - ((p[6] + p[1]) <<< 1);
				e2 = (p[7] - p[8]) <<< 1;
			end
			default: begin
				e0 = (p[4] - p[5]) <<< 1;
				e1 = (p[7] + p[8]) <<< 1;
				e2 = ONE_X - ((p[6] + p[0]) <<< 1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		tag_q  <= ctl.mul_job;
		if (ctl.load) begin
			axis_q[0] <= sat_w(XW'(axis_x));
			axis_q[1] <= sat_w(XW'(axis_y));
			axis_q[2] <= sat_w(XW'(axis_z));
			if (in_cmd == CMD_MULT) begin
				q_q[0] <= sat_w(XW'(other_w));
				q_q[1] <= sat_w(XW'(other_x));
				q_q[2] <= sat_w(XW'(other_y));
				q_q[3] <= sat_w(XW'(other_z));
			end
			m_q <= '0;
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
			cx_q <= CORDIC_K;
			cy_q <= '0;
			if (z0 > HALF_PI_Q30) begin
				cz_q  <= z0 - PI_Q30;
				neg_q <= 1'b1;
			end else if (z0 < -HALF_PI_Q30) begin
				cz_q  <= z0 + PI_Q30;
				neg_q <= 1'b1;
			end else begin
				cz_q  <= z0;
				neg_q <= 1'b0;
			end
		end
		if (ctl.cordic_step) begin
			if (!cz_q[CW-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end
		end
		if (ctl.cordic_fin) begin
			q_q[0] <= sat_w(XW'(xf >>> (30 - F)));
			s_q    <= sat_w(XW'(yf >>> (30 - F)));
		end
		if (tag_vld_q) begin
			if (tag_q < JOB_SQUARE) begin
				q_q[2'(tag_q[1:0] + 2'd1)] <= sat_w(XW'(rnd));
			end else if (tag_q < JOB_QMUL) begin
				m_q <= m_q + (unsigned'(prod_q) >> 2);
			end else if (tag_q < JOB_MAT) begin
				if (qmul_neg(trel[3:2], trel[1:0]))
					acc_q[trel[3:2]] <= acc_q[trel[3:2]] - AW'(rnd);
				else
					acc_q[trel[3:2]] <= acc_q[trel[3:2]] + AW'(rnd);
			end else begin
				mp_q[4'(tag_q - JOB_MAT)] <= rnd;
			end
		end
		if (ctl.sqrt_init) begin
			sv_q   <= m_q;
			sres_q <= '0;
			sbit_q <= PW'(1) << (PW - 2);
		end
		if (ctl.sqrt_step) begin
			if (sv_q >= st_sum) begin
				sv_q   <= sv_q - st_sum;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
		if (ctl.div_init) begin
			rem_q   <= {1'b0, num[PW-1:W]};
			numlo_q <= num[W-1:0];
			quo_q   <= '0;
			ovf_q   <= num[PW-1:W] >= root;
			ng_q    <= q_q[ctl.div_k][W-1];
		end
		if (ctl.div_step) begin
			if (rem2 >= {1'b0, root}) begin
				rem_q <= rem2 - {1'b0, root};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
			numlo_q <= numlo_q << 1;
		end
		if (ctl.div_fin) q_q[ctl.div_k] <= qdiv;
		if (ctl.out_load) begin
			row_q    <= ctl.out_row;
			col_q[0] <= sat_w(e0);
			col_q[1] <= sat_w(e1);
			col_q[2] <= sat_w(e2);
			for (int i = 0; i < 4; i++) qo_q[i] <= orient_q[i];
			last_q   <= ctl.out_row == 2'd2;
		end
	end

	// orientation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q[0] <= ONE_W;
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
		end else if (ctl.load && in_cmd == CMD_RESET) begin
			orient_q[0] <= ONE_W;
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
		end else if (ctl.commit) begin
			for (int i = 0; i < 4; i++) orient_q[i] <= sat_w(XW'(acc_q[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_vld_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			tag_vld_q <= ctl.mul_en;
			if (ctl.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	assign stat.renorm_req = (64'(m_q) > HI_TH) || (64'(m_q) < LO_TH);
	assign stat.root_zero  = root == '0;
	assign stat.out_free   = !out_valid || out_ready;

	assign row_index = row_q;
	assign col_zero  = 32'(col_q[0]);
	assign col_one   = 32'(col_q[1]);
	assign col_two   = 32'(col_q[2]);
	assign quat_w    = 32'(qo_q[0]);
	assign quat_x    = 32'(qo_q[1]);
	assign quat_y    = 32'(qo_q[2]);
	assign quat_z    = 32'(qo_q[3]);
	assign last_row  = last_q;

endmodule
`default_nettype wire
